FILE: rtl/ssst_pkg.sv
// ----------------------------------------------------------------------------
// ssst_pkg
// Shared types, constants and tables for the speed and steering step block.
// ----------------------------------------------------------------------------
`default_nettype none

package ssst_pkg;

  // Register indexes of the configuration port.
  localparam int unsigned CfgIdxW = 8;
  localparam logic [CfgIdxW-1:0] CFG_SPEED_LIMIT = 8'd0;
  localparam logic [CfgIdxW-1:0] CFG_STEER_LIMIT = 8'd1;
  localparam logic [CfgIdxW-1:0] CFG_DIST_GAIN   = 8'd2;
  localparam logic [CfgIdxW-1:0] CFG_DAMP_GAIN   = 8'd3;

  // Reset values.
  localparam logic [30:0] SPEED_LIMIT_RST = 31'd65536;
  localparam logic [30:0] STEER_LIMIT_RST = 31'd32768;
  localparam logic [30:0] DIST_GAIN_RST   = 31'd65536;
  localparam logic [30:0] DAMP_GAIN_RST   = 31'd0;
  localparam logic signed [31:0] SPEED_RST = 32'sd6554;

  localparam int unsigned RootSteps   = 32;
  localparam int unsigned CordicSteps = 16;

  // Controller states.
  typedef enum logic [3:0] {
    S_IDLE, S_SQX, S_SQY, S_SUM, S_ROOT, S_MULA, S_MULB,
    S_SPEED, S_NORM, S_ROT, S_FIN
  } state_e;

  // Datapath operations.
  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_SQX, OP_SQY, OP_SUM, OP_ROOT, OP_MULA,
    OP_MULB, OP_SPEED, OP_NORM, OP_ROT, OP_FIN
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [4:0] step;
  } ssst_cmd_t;

  typedef struct packed {
    logic spd_pos;
    logic norm_ok;
  } ssst_status_t;

  // Arctangent of 2^-i in Q16.16, rounded.
  function automatic logic [15:0] atan_entry(input logic [3:0] i);
    logic [15:0] r;
    case (i)
      4'd0:    r = 16'd51472;
      4'd1:    r = 16'd30386;
      4'd2:    r = 16'd16055;
      4'd3:    r = 16'd8150;
      4'd4:    r = 16'd4091;
      4'd5:    r = 16'd2047;
      4'd6:    r = 16'd1024;
      4'd7:    r = 16'd512;
      4'd8:    r = 16'd256;
      4'd9:    r = 16'd128;
      4'd10:   r = 16'd64;
      4'd11:   r = 16'd32;
      4'd12:   r = 16'd16;
      4'd13:   r = 16'd8;
      4'd14:   r = 16'd4;
      default: r = 16'd2;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/ssst_if.sv
// ----------------------------------------------------------------------------
// ssst_if
// Valid/ready channel interfaces for input items, results and configuration.
// ----------------------------------------------------------------------------
`default_nettype none

interface ssst_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] offset_x;
  logic [31:0] offset_y;
  logic [31:0] heading_error;
  modport source (output valid, offset_x, offset_y, heading_error, input ready);
  modport sink   (input valid, offset_x, offset_y, heading_error, output ready);
endinterface

interface ssst_out_if;
  logic        valid;
  logic        ready;
  logic [30:0] speed_cmd;
  logic [31:0] steer_cmd;
  modport source (output valid, speed_cmd, steer_cmd, input ready);
  modport sink   (input valid, speed_cmd, steer_cmd, output ready);
endinterface

interface ssst_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/ssst_ctrl.sv
// ----------------------------------------------------------------------------
// ssst_ctrl
// Sequencer that steps the datapath through square root, gains and CORDIC.
// ----------------------------------------------------------------------------
`default_nettype none

module ssst_ctrl
  import ssst_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   in_valid_i,
  output logic        in_ready_o,
  output logic        out_valid_o,
  input  wire logic   out_ready_i,
  input  ssst_status_t status_i,
  output ssst_cmd_t   cmd_o
);

  state_e     state_q, state_d;
  logic [4:0] cnt_q, cnt_d;
  logic       out_valid_q, out_valid_d;
  logic       fin_fire;

  // State, step counter and result flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and datapath command.
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o.op   = OP_NONE;
    cmd_o.step = cnt_q;
    fin_fire   = 1'b0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = S_SQX;
        end
      end
      S_SQX: begin
        cmd_o.op = OP_SQX;
        state_d  = S_SQY;
      end
      S_SQY: begin
        cmd_o.op = OP_SQY;
        state_d  = S_SUM;
      end
      S_SUM: begin
        cmd_o.op = OP_SUM;
        cnt_d    = '0;
        state_d  = S_ROOT;
      end
      S_ROOT: begin
        cmd_o.op = OP_ROOT;
        cnt_d    = cnt_q + 5'd1;
        if (cnt_q == 5'(RootSteps - 1)) state_d = S_MULA;
      end
      S_MULA: begin
        cmd_o.op = OP_MULA;
        state_d  = S_MULB;
      end
      S_MULB: begin
        cmd_o.op = OP_MULB;
        state_d  = S_SPEED;
      end
      S_SPEED: begin
        cmd_o.op = OP_SPEED;
        state_d  = S_NORM;
      end
      S_NORM: begin
        cnt_d = '0;
        if (!status_i.spd_pos) begin
          state_d = S_FIN;
        end else if (status_i.norm_ok) begin
          state_d = S_ROT;
        end else begin
          cmd_o.op = OP_NORM;
        end
      end
      S_ROT: begin
        cmd_o.op = OP_ROT;
        cnt_d    = cnt_q + 5'd1;
        if (cnt_q == 5'(CordicSteps - 1)) state_d = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.op = OP_FIN;
          fin_fire = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_d = fin_fire | (out_valid_q & ~out_ready_i);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

FILE: rtl/ssst_datapath.sv
// ----------------------------------------------------------------------------
// ssst_datapath
// Shared multiplier, bit-serial square root, speed update and CORDIC unit.
// ----------------------------------------------------------------------------
`default_nettype none

module ssst_datapath
  import ssst_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  ssst_cmd_t         cmd_i,
  output ssst_status_t      status_o,
  input  wire logic [31:0]  offset_x_i,
  input  wire logic [31:0]  offset_y_i,
  input  wire logic [31:0]  heading_error_i,
  input  wire logic         cfg_we_i,
  input  wire logic [7:0]   cfg_index_i,
  input  wire logic [31:0]  cfg_data_i,
  output logic [30:0]       speed_cmd_o,
  output logic [31:0]       steer_cmd_o
);

  // Configuration registers.
  logic [30:0] speed_limit_q, steer_limit_q, dist_gain_q, damp_gain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_limit_q <= SPEED_LIMIT_RST;
      steer_limit_q <= STEER_LIMIT_RST;
      dist_gain_q   <= DIST_GAIN_RST;
      damp_gain_q   <= DAMP_GAIN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_SPEED_LIMIT: speed_limit_q <= cfg_data_i[30:0];
        CFG_STEER_LIMIT: steer_limit_q <= cfg_data_i[30:0];
        CFG_DIST_GAIN:   dist_gain_q   <= cfg_data_i[30:0];
        CFG_DAMP_GAIN:   damp_gain_q   <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  // Stored speed.
  logic signed [31:0] prev_q, prev_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) prev_q <= SPEED_RST;
    else         prev_q <= prev_d;
  end

  // Working registers.
  logic signed [31:0] x_in_q, y_in_q, yaw_q;
  logic signed [65:0] prod_q;
  logic [63:0]        acc_q;
  logic [32:0]        rem_q;
  logic [31:0]        root_q;
  logic [46:0]        gain_a_q;
  logic signed [47:0] cx_q, cy_q;
  logic signed [18:0] z_q;
  logic [30:0]        speed_q;
  logic [31:0]        steer_q;

  // Shared multiplier operand selection.
  logic signed [32:0] mul_a, mul_b;
  always_comb begin
    mul_a = {x_in_q[31], x_in_q};
    mul_b = {x_in_q[31], x_in_q};
    case (cmd_i.op)
      OP_SQY: begin
        mul_a = {y_in_q[31], y_in_q};
        mul_b = {y_in_q[31], y_in_q};
      end
      OP_MULA: begin
        mul_a = $signed({2'b00, dist_gain_q});
        mul_b = $signed({1'b0, root_q});
      end
      OP_MULB: begin
        mul_a = $signed({2'b00, damp_gain_q});
        mul_b = {prev_q[31], prev_q};
      end
      default: ;
    endcase
  end

  // One square root digit per cycle.
  logic [34:0] rem_n, trial;
  logic        take;
  assign rem_n = {rem_q, acc_q[63:62]};
  assign trial = {1'b0, root_q, 2'b01};
  assign take  = rem_n >= trial;

  // Speed update: floor shifts, saturation and upper clip.
  logic signed [49:0] gain_b;
  logic signed [50:0] diff;
  logic signed [31:0] sat_sp, new_sp;
  assign gain_b = prod_q[65:16];
  assign diff   = $signed({4'b0000, gain_a_q}) - {gain_b[49], gain_b};
  always_comb begin
    if (diff > 51'sd2147483647)       sat_sp = 32'sh7fffffff;
    else if (diff < -51'sd2147483648) sat_sp = 32'sh80000000;
    else                              sat_sp = diff[31:0];
    if (sat_sp > $signed({1'b0, speed_limit_q})) new_sp = $signed({1'b0, speed_limit_q});
    else                                         new_sp = sat_sp;
  end

  // Normalization test before CORDIC.
  logic [47:0] abs_y, mag;
  assign abs_y = cy_q[47] ? 48'(-cy_q) : 48'(cy_q);
  assign mag   = (48'(cx_q) > abs_y) ? 48'(cx_q) : abs_y;
  assign status_o.norm_ok = |mag[47:40];
  assign status_o.spd_pos = (prev_q > 32'sd0);

  // CORDIC vectoring step.
  logic signed [47:0] xs, ys;
  logic signed [18:0] ang;
  assign xs  = cx_q >>> cmd_i.step[3:0];
  assign ys  = cy_q >>> cmd_i.step[3:0];
  assign ang = $signed({3'b000, atan_entry(cmd_i.step[3:0])});

  // Final steering sum, saturation and symmetric clip; zero when the speed is not positive.
  logic signed [32:0] st_sum, lim;
  logic signed [31:0] st_sat, st_clip;
  assign st_sum = {yaw_q[31], yaw_q} + 33'(z_q);
  assign lim    = $signed({2'b00, steer_limit_q});
  always_comb begin
    if (st_sum > 33'sd2147483647)       st_sat = 32'sh7fffffff;
    else if (st_sum < -33'sd2147483648) st_sat = 32'sh80000000;
    else                                st_sat = st_sum[31:0];
    if (!status_o.spd_pos)           st_clip = '0;
    else if (33'(st_sat) > lim)      st_clip = lim[31:0];
    else if (33'(st_sat) < -lim)     st_clip = 32'(-lim);
    else                             st_clip = st_sat;
  end

  always_comb begin
    prev_d = prev_q;
    if (cmd_i.op == OP_SPEED) prev_d = new_sp;
  end

  // Operation registers.
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        x_in_q <= offset_x_i;
        y_in_q <= offset_y_i;
        yaw_q  <= heading_error_i;
        rem_q  <= '0;
        root_q <= '0;
      end
      OP_SQX: prod_q <= mul_a * mul_b;
      OP_SQY: begin
        acc_q  <= prod_q[63:0];
        prod_q <= mul_a * mul_b;
      end
      OP_SUM: acc_q <= acc_q + prod_q[63:0];
      OP_ROOT: begin
        acc_q <= {acc_q[61:0], 2'b00};
        if (take) begin
          rem_q  <= 33'(rem_n - trial);
          root_q <= {root_q[30:0], 1'b1};
        end else begin
          rem_q  <= rem_n[32:0];
          root_q <= {root_q[30:0], 1'b0};
        end
      end
      OP_MULA: prod_q <= mul_a * mul_b;
      OP_MULB: begin
        gain_a_q <= prod_q[62:16];
        prod_q   <= mul_a * mul_b;
      end
      OP_SPEED: begin
        cx_q <= {{15{new_sp[31]}}, new_sp, 1'b0};
        cy_q <= {{16{y_in_q[31]}}, y_in_q};
        z_q  <= '0;
      end
      OP_NORM: begin
        if (mag[47:32] == 16'd0) begin
          cx_q <= cx_q <<< 8;
          cy_q <= cy_q <<< 8;
        end else begin
          cx_q <= cx_q <<< 1;
          cy_q <= cy_q <<< 1;
        end
      end
      OP_ROT: begin
        if (!cy_q[47]) begin
          cx_q <= cx_q + ys;
          cy_q <= cy_q - xs;
          z_q  <= z_q + ang;
        end else begin
          cx_q <= cx_q - ys;
          cy_q <= cy_q + xs;
          z_q  <= z_q - ang;
        end
      end
      OP_FIN: begin
        speed_q <= prev_q[31] ? 31'd0 : prev_q[30:0];
        steer_q <= st_clip;
      end
      default: ;
    endcase
  end

  assign speed_cmd_o = speed_q;
  assign steer_cmd_o = steer_q;

endmodule

`default_nettype wire

FILE: rtl/stanley_speed_steering_step.sv
// ----------------------------------------------------------------------------
// stanley_speed_steering_step
// Speed and steering command from a target offset and a heading error.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries offset_x, offset_y and heading_error (signed Q16.16); one
//   result with speed_cmd and steer_cmd leaves on out_o for each item.
//   cfg_i writes speed_limit, steer_limit, dist_gain and damp_gain by index;
//   it is always ready; the user must ensure that it is written only while
//   the block is idle, as the block itself does not enforce this. An item
//   passes through the squares and their sum, the bit-serial square root,
//   the two gain products and the speed update through the shared multiplier,
//   a range check with normalizing shifts, 16 CORDIC steps and the write of
//   the result; when the new speed is not positive, the normalizing shifts
//   and CORDIC steps are skipped. Items are worked one at a time, and a new
//   item is taken once the block is idle again after writing each result.
//   The result is held in an output register; the next item is taken while
//   it waits, and the block stalls before writing a new result until the
//   receiver has taken the old one.
//   Reset restores the register defaults and sets the stored speed to 0.1.
// ----------------------------------------------------------------------------
`default_nettype none

module stanley_speed_steering_step
  import ssst_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  ssst_in_if.sink   in_i,
  ssst_out_if.source out_o,
  ssst_cfg_if.sink  cfg_i
);

  ssst_cmd_t    cmd;
  ssst_status_t status;

  assign cfg_i.ready = 1'b1;

  // Sequencer.
  ssst_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Arithmetic.
  ssst_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .offset_x_i      (in_i.offset_x),
    .offset_y_i      (in_i.offset_y),
    .heading_error_i (in_i.heading_error),
    .cfg_we_i        (cfg_i.valid),
    .cfg_index_i     (cfg_i.index),
    .cfg_data_i      (cfg_i.data),
    .speed_cmd_o     (out_o.speed_cmd),
    .steer_cmd_o     (out_o.steer_cmd)
  );

endmodule

`default_nettype wire

FILE: rtl/ssst_checker.sv
// ----------------------------------------------------------------------------
// ssst_checker
// Port-level checks of the speed and steering step block.
// ----------------------------------------------------------------------------
`default_nettype none

module ssst_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_i,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic [30:0] speed_cmd_i,
  input wire logic [31:0] steer_cmd_i
);

  // A waiting result stays until transferred.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped before transfer");

  // After an input transfer the block is busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input taken while busy");

  // A zero speed command comes with zero steering.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && speed_cmd_i == 31'd0 |-> steer_cmd_i == 32'd0)
    else $error("steering without speed");

  // A new result appears only at the end of work.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> !$past(in_ready_i))
    else $error("result without work");

endmodule

bind stanley_speed_steering_step ssst_checker u_ssst_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .speed_cmd_i (out_o.speed_cmd),
  .steer_cmd_i (out_o.steer_cmd)
);

`default_nettype wire
